// File: hdl/bcf_pkg.sv
// Shared types and constants of the Bezier curve flattener.
package bcf_pkg;

	// Configuration port geometry: one 32-bit register at byte address 0.
	localparam int PADDR_W = 3;
	localparam int CFG_W = 3;
	localparam logic [PADDR_W-3:0] REG_SEG_LOG2 = '0;
	localparam logic [CFG_W-1:0] SEG_LOG2_RESET = 3'd6;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SETUP  = 7'b0000010,
		ST_INIT_X = 7'b0000100,
		ST_INIT_Y = 7'b0001000,
		ST_STEP_X = 7'b0010000,
		ST_STEP_Y = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

endpackage

// File: hdl/bezier_curve_flattener.sv
// Top level of the Bezier curve flattener: curve in, line segments out.
//
// Usage:
//   One input transfer on s_axis carries a whole quadratic or cubic curve:
//   eight signed control point coordinates in tdata and the cubic flag in
//   tuser. The block emits N = 2^segments_log2 segments on m_axis, each from
//   the previous sample to the next one, sampled at t = i/N, i = 1..N; tlast
//   marks the final segment, which always ends on the curve's end point.
//   segments_log2 sits at APB address 0; 0 reads as 1, values above
//   MAX_SEG_LOG2 act as MAX_SEG_LOG2. Write it only while the block is idle.
// Timing:
//   The curve is walked by exact integer forward differencing. One shared
//   difference unit updates one axis per cycle, so a segment takes an x step,
//   a y step and a truncate and emit step; the first is preceded by a setup
//   step and an x and a y init step. s_axis_tready rises again once the last
//   segment is loaded into the output register.
// Reset and stalls:
//   arst_n clears the sequencer and the output valid flag and sets
//   segments_log2 to 6. A stalled receiver holds the segment in the output
//   register and the sequencer waits in its emit step; nothing is dropped.
module bezier_curve_flattener #(
	parameter int COORD_BITS   = 12,
	parameter int MAX_SEG_LOG2 = 6
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// curve input
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
	input  logic [8*COORD_BITS-1:0]                  s_axis_tdata,
	// is_cubic
	input  logic [0:0]                               s_axis_tuser,
	// segment output
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// seg_from_x, seg_from_y, seg_to_x, seg_to_y, zero padding
	output logic [((4*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
	output logic                                     m_axis_tlast,
	// configuration
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [bcf_pkg::PADDR_W-1:0]              paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);
	import bcf_pkg::*;

	localparam int OUT_DATA_W = ((4*COORD_BITS+7)/8)*8;
	// Scaled sums reach 2^(COORD_BITS-1+3*MAX_SEG_LOG2) in magnitude.
	localparam int ACC_W = COORD_BITS + 3*MAX_SEG_LOG2 + 4;
	// Narrow setup terms: up to 6 * third difference of the control points.
	localparam int NW    = COORD_BITS + 6;
	localparam int CNT_W = MAX_SEG_LOG2 + 1;
	localparam int SH_W  = $clog2(3*MAX_SEG_LOG2 + 1);

	// ---------------- configuration register ----------------
	logic [CFG_W-1:0] seg_log2_q;
	logic             cfg_wr;
	logic             cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[PADDR_W-1:2] == REG_SEG_LOG2);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? {{(32-CFG_W){1'b0}}, seg_log2_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_log2_q <= SEG_LOG2_RESET;
		end else if (cfg_wr) begin
			seg_log2_q <= pwdata[CFG_W-1:0];
		end
	end

	// Clamp the segment count exponent into 1..MAX_SEG_LOG2.
	logic [CFG_W-1:0] k_eff;
	always_comb begin
		priority if (seg_log2_q == '0) begin
			k_eff = CFG_W'(1);
		end else if (seg_log2_q > CFG_W'(MAX_SEG_LOG2)) begin
			k_eff = CFG_W'(MAX_SEG_LOG2);
		end else begin
			k_eff = seg_log2_q;
		end
	end

	// ---------------- sequencer state ----------------
	state_t                 state_q;
	logic [CNT_W-1:0]       seg_q;
	logic [CFG_W-1:0]       k_q;
	logic                   cubic_q;
	logic                   out_valid_q;
	logic                   out_last_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	// held curve and forward difference registers, index 0 is x, 1 is y
	logic signed [COORD_BITS-1:0] pt_q   [8];
	logic signed [COORD_BITS-1:0] prev_q [2];
	logic signed [NW-1:0]         ca_q   [2];
	logic signed [NW-1:0]         cb_q   [2];
	logic signed [NW-1:0]         cc_q   [2];
	logic signed [NW-1:0]         cc6_q  [2];
	logic signed [ACC_W-1:0]      s_q    [2];
	logic signed [ACC_W-1:0]      d1_q   [2];
	logic signed [ACC_W-1:0]      d2_q   [2];
	logic signed [ACC_W-1:0]      d3_q   [2];
	logic        [ACC_W-1:0]      round_q;

	logic in_xfer;
	logic out_free;
	logic emit_load;
	logic is_last;
	logic ax;
	logic [CNT_W-1:0] seg_total;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign seg_total     = CNT_W'(1) << k_q;
	assign is_last       = (seg_q == seg_total);
	assign emit_load     = (state_q == ST_EMIT) && out_free;
	assign ax            = (state_q == ST_INIT_Y) || (state_q == ST_STEP_Y);

	// Shift amounts: sum is scaled by N^3 (cubic) or N^2 (quadratic).
	logic [SH_W-1:0] k_sh;
	logic [SH_W-1:0] sh_sum;
	logic [SH_W-1:0] sh_a;
	logic [SH_W-1:0] sh_b;
	assign k_sh   = SH_W'(k_q);
	assign sh_sum = cubic_q ? SH_W'(3*k_sh) : SH_W'(2*k_sh);
	assign sh_a   = cubic_q ? SH_W'(2*k_sh) : SH_W'(k_sh + SH_W'(1));
	assign sh_b   = cubic_q ? k_sh : '0;

	// Setup: control point differences in power-basis form, both axes.
	// Cubic:     S(i) = N^3 p0 + 3N^2 e i + 3N h i^2 + c i^3
	// Quadratic: S(i) = N^2 p0 + 2N e i + h i^2
	logic signed [NW-1:0] ca_n  [2];
	logic signed [NW-1:0] cb_n  [2];
	logic signed [NW-1:0] cc_n  [2];
	logic signed [NW-1:0] cc6_n [2];
	always_comb begin
		logic signed [NW-1:0] e;
		logic signed [NW-1:0] f;
		logic signed [NW-1:0] g;
		logic signed [NW-1:0] h;
		logic signed [NW-1:0] c;
		for (int a = 0; a < 2; a++) begin
			e = NW'(pt_q[2+a]) - NW'(pt_q[a]);
			f = NW'(pt_q[4+a]) - NW'(pt_q[2+a]);
			g = NW'(pt_q[6+a]) - NW'(pt_q[4+a]);
			h = f - e;
			c = g - f - h;
			ca_n[a]  = cubic_q ? (e + (e <<< 1)) : e;
			cb_n[a]  = cubic_q ? (h + (h <<< 1)) : h;
			cc_n[a]  = cubic_q ? c : '0;
			cc6_n[a] = (cc_n[a] <<< 2) + (cc_n[a] <<< 1);
		end
	end

	// Init: differences at i = 0 for the selected axis.
	logic signed [ACC_W-1:0] coef_a;
	logic signed [ACC_W-1:0] coef_b;
	logic signed [ACC_W-1:0] s_init;
	logic signed [ACC_W-1:0] d1_init;
	logic signed [ACC_W-1:0] d2_init;
	logic signed [ACC_W-1:0] d3_init;
	always_comb begin
		coef_a  = ACC_W'(ca_q[ax]) <<< sh_a;
		coef_b  = ACC_W'(cb_q[ax]) <<< sh_b;
		d1_init = coef_a + coef_b + ACC_W'(cc_q[ax]);
		d2_init = (coef_b <<< 1) + ACC_W'(cc6_q[ax]);
		d3_init = ACC_W'(cc6_q[ax]);
		s_init  = ACC_W'(pt_q[{2'b00, ax}]) <<< sh_sum;
	end

	// Shared difference unit: advance one axis by one sample.
	logic signed [ACC_W-1:0] s_step;
	logic signed [ACC_W-1:0] d1_step;
	logic signed [ACC_W-1:0] d2_step;
	assign s_step  = s_q[ax] + d1_q[ax];
	assign d1_step = d1_q[ax] + d2_q[ax];
	assign d2_step = d2_q[ax] + d3_q[ax];

	// Emit: divide by the scale, truncating toward zero (bias negatives).
	logic signed [COORD_BITS-1:0] to_n [2];
	always_comb begin
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] quot;
		for (int a = 0; a < 2; a++) begin
			biased  = s_q[a] + (s_q[a][ACC_W-1] ? signed'(round_q) : ACC_W'(0));
			quot    = biased >>> sh_sum;
			to_n[a] = quot[COORD_BITS-1:0];
		end
	end

	logic [OUT_DATA_W-1:0] out_data_n;
	always_comb begin
		out_data_n = '0;
		out_data_n[0*COORD_BITS +: COORD_BITS] = prev_q[0];
		out_data_n[1*COORD_BITS +: COORD_BITS] = prev_q[1];
		out_data_n[2*COORD_BITS +: COORD_BITS] = to_n[0];
		out_data_n[3*COORD_BITS +: COORD_BITS] = to_n[1];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new segment, else drop the held one once it transfers
			out_valid_q <= emit_load || (out_valid_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						seg_q   <= CNT_W'(1);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP:  state_q <= ST_INIT_X;
				ST_INIT_X: state_q <= ST_INIT_Y;
				ST_INIT_Y: state_q <= ST_STEP_X;
				ST_STEP_X: state_q <= ST_STEP_Y;
				ST_STEP_Y: state_q <= ST_EMIT;
				ST_EMIT: begin
					// hold here while the output register is still full
					if (out_free) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							seg_q   <= seg_q + CNT_W'(1);
							state_q <= ST_STEP_X;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int j = 0; j < 8; j++) begin
				pt_q[j] <= s_axis_tdata[j*COORD_BITS +: COORD_BITS];
			end
			prev_q[0] <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
			prev_q[1] <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
			cubic_q   <= s_axis_tuser[0];
			k_q       <= k_eff;
		end
		if (state_q == ST_SETUP) begin
			for (int a = 0; a < 2; a++) begin
				ca_q[a]  <= ca_n[a];
				cb_q[a]  <= cb_n[a];
				cc_q[a]  <= cc_n[a];
				cc6_q[a] <= cc6_n[a];
			end
			round_q <= (ACC_W'(1) << sh_sum) - ACC_W'(1);
		end
		if ((state_q == ST_INIT_X) || (state_q == ST_INIT_Y)) begin
			s_q[ax]  <= s_init;
			d1_q[ax] <= d1_init;
			d2_q[ax] <= d2_init;
			d3_q[ax] <= d3_init;
		end
		if ((state_q == ST_STEP_X) || (state_q == ST_STEP_Y)) begin
			s_q[ax]  <= s_step;
			d1_q[ax] <= d1_step;
			d2_q[ax] <= d2_step;
		end
		if (emit_load) begin
			out_data_q <= out_data_n;
			out_last_q <= is_last;
			prev_q[0]  <= to_n[0];
			prev_q[1]  <= to_n[1];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// ---------------- assertions ----------------
	logic signed [COORD_BITS-1:0] end_x_sel;
	assign end_x_sel = cubic_q ? pt_q[6] : pt_q[4];

	// An accepted curve always starts with the setup step.
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_SETUP))
		else $error("curve accepted but sequencer did not enter setup");

	// The segment counter never runs past the curve's segment count.
	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (seg_q <= seg_total))
		else $error("segment counter past segment count");

	// The last segment ends exactly on the curve's end point in x.
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && is_last) |=>
		(m_axis_tdata[2*COORD_BITS +: COORD_BITS] == $past(end_x_sel)))
		else $error("last segment does not end on the end point");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the Bezier curve flattener.
module testbench;
	import bcf_pkg::*;

	localparam int CB         = 12;
	localparam int OUT_W      = ((4*CB+7)/8)*8;
	localparam int STALL_MAX  = 3000;   // cycles with no transfer before the run is abandoned
	localparam int HOLD_LEN   = 200;    // long receiver hold-off, in cycles

	// Curve as it travels on s_axis: pts[0] = start_x in the lowest bits.
	typedef struct packed {
		logic                 cubic;
		logic [7:0][CB-1:0]   pts;
	} curve_t;

	typedef struct packed {
		logic signed [CB-1:0] from_x;
		logic signed [CB-1:0] from_y;
		logic signed [CB-1:0] to_x;
		logic signed [CB-1:0] to_y;
		logic                 last;
	} segment_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	// start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
	logic [8*CB-1:0]              s_axis_tdata;
	// is_cubic
	logic [0:0]                   s_axis_tuser;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	// seg_from_x, seg_from_y, seg_to_x, seg_to_y
	logic [OUT_W-1:0]             m_axis_tdata;
	logic                         m_axis_tlast;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [PADDR_W-1:0]           paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	// Segments still owed by the block, oldest first.
	segment_t segments_due[$];

	logic [CFG_W-1:0] seg_log2_cfg;     // our copy of segments_log2
	bit               idle_on;          // random gaps on both sides
	int               hold_off_len;     // request for one long receiver stall
	int               errors;
	int               curves_sent;
	int               cubic_sent;
	int               segments_seen;
	int               cfg_writes;
	logic [7:0]       k_used;           // effective log2 segment counts exercised
	int               stall_cycles;

	bezier_curve_flattener #(
		.COORD_BITS   (CB),
		.MAX_SEG_LOG2 (6)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Print one line per mismatch and count every one.
	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH at segment %0d: %s got %0d, want %0d",
			segments_seen, what, got, want);
	endtask

	// Work out the N segments of one curve at the current setting and queue them.
	// Each sample is the exact Bernstein sum scaled by N^2 or N^3, truncated
	// toward zero; the first segment starts on the start point itself.
	function automatic void predict_segments(input curve_t c);
		int       k;
		int       sh;
		longint   n;
		longint   u;
		longint   sum;
		longint   pt[8];
		longint   prev[2];
		longint   smp[2];
		segment_t s;
		k = seg_log2_cfg;
		if (k < 1)
			k = 1;
		if (k > 6)
			k = 6;
		k_used[k] = 1'b1;
		n = longint'(1) << k;
		for (int j = 0; j < 8; j++)
			pt[j] = $signed(c.pts[j]);
		prev[0] = pt[0];
		prev[1] = pt[1];
		for (longint i = 1; i <= n; i++) begin
			u = n - i;
			for (int a = 0; a < 2; a++) begin
				if (c.cubic) begin
					sum = u*u*u*pt[a] + 3*u*u*i*pt[2+a] + 3*u*i*i*pt[4+a] + i*i*i*pt[6+a];
					sh = 3 * k;
				end else begin
					// quadratic: end point is ignored, curve ends on ctrl_b
					sum = u*u*pt[a] + 2*u*i*pt[2+a] + i*i*pt[4+a];
					sh = 2 * k;
				end
				smp[a] = (sum < 0) ? -((-sum) >> sh) : (sum >> sh);
			end
			s.from_x = 12'(prev[0]);
			s.from_y = 12'(prev[1]);
			s.to_x   = 12'(smp[0]);
			s.to_y   = 12'(smp[1]);
			s.last   = (i == n);
			segments_due.push_back(s);
			prev = smp;
		end
	endfunction

	function automatic curve_t make_curve(input bit cubic, input int sx, input int sy,
		input int ax, input int ay, input int bx, input int by, input int ex, input int ey);
		curve_t c;
		c.cubic  = cubic;
		c.pts[0] = 12'(sx);
		c.pts[1] = 12'(sy);
		c.pts[2] = 12'(ax);
		c.pts[3] = 12'(ay);
		c.pts[4] = 12'(bx);
		c.pts[5] = 12'(by);
		c.pts[6] = 12'(ex);
		c.pts[7] = 12'(ey);
		return c;
	endfunction

	// Coordinate by style: full range, extremes, or a few pixels around zero.
	function automatic logic [CB-1:0] pick_coord(input int style);
		int corner[5] = '{-2048, 2047, 0, -1, 1};
		case (style)
			1:       return 12'(corner[$urandom_range(0, 4)]);
			2:       return 12'($urandom_range(0, 16) - 8);
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic curve_t random_curve();
		curve_t c;
		int     style;
		int     r;
		r = $urandom_range(0, 19);
		style = (r < 12) ? 0 : (r < 15) ? 1 : (r < 18) ? 2 : 3;
		c.cubic = 1'($urandom_range(0, 1));
		for (int j = 0; j < 8; j++)
			c.pts[j] = pick_coord(style == 3 ? 0 : style);
		// degenerate curve: every control point on one spot
		if (style == 3) begin
			for (int j = 2; j < 8; j++)
				c.pts[j] = c.pts[j % 2];
		end
		return c;
	endfunction

	// Offer one curve, maybe after a short gap, and hold it until the transfer.
	task automatic send_curve(input curve_t c);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom, $urandom};
			s_axis_tuser  <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c.pts;
		s_axis_tuser  <= c.cubic;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_segments(c);
		curves_sent++;
		if (c.cubic)
			cubic_sent++;
	endtask

	// Drop valid and wait until every owed segment has arrived and the block settles.
	task automatic drain_segments();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (segments_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Setup then access phase; the write lands on the edge with pready high.
	task automatic write_seg_log2(input logic [CFG_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {REG_SEG_LOG2, 2'b00};
		pwdata  <= {(32 - CFG_W)'($urandom_range(0, (1 << (32 - CFG_W)) - 1)), v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		seg_log2_cfg = v;
		cfg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Corner curves at the reset setting of 64 segments.
	task automatic test_directed_curves();
		send_curve(make_curve(1, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048));
		send_curve(make_curve(1,  2047,  2047,  2047,  2047,  2047,  2047,  2047,  2047));
		send_curve(make_curve(0, -2048, -2048, -2048, -2048, -2048, -2048,  2047,  2047));
		send_curve(make_curve(0,  2047,  2047,  2047,  2047,  2047,  2047, -2048, -2048));
		// widest swing, x and y in opposite phase
		send_curve(make_curve(1, -2048,  2047,  2047, -2048, -2048,  2047,  2047, -2048));
		send_curve(make_curve(0, -2048,  2047,  2047, -2048, -2048,  2047,     0,     0));
		// alternating bit patterns
		send_curve(make_curve(1, 'haaa, 'h555, 'h555, 'haaa, 'haaa, 'h555, 'h555, 'haaa));
		send_curve(make_curve(0, 'h555, 'haaa, 'haaa, 'h555, 'h555, 'haaa, 'haaa, 'h555));
		// same quadratic twice with different end fields, which must not matter
		send_curve(make_curve(0, 100, -300, 900, 1500, -700, 40, 1234, -1234));
		send_curve(make_curve(0, 100, -300, 900, 1500, -700, 40, -2048, 2047));
		// small negative sums, truncated toward zero
		send_curve(make_curve(1, -1, -1, -2, -3, -1, -2, -3, -1));
		send_curve(make_curve(0, -1, 1, -3, 2, -1, -1, 0, 0));
		send_curve(make_curve(1, 0, 0, 0, 0, 0, 0, 0, 0));
		drain_segments();
	endtask

	// Register out of range on both sides, then the smallest legal setting.
	task automatic test_register_limits();
		write_seg_log2(3'd0);
		send_curve(make_curve(1, -2048, 2047, 500, -500, -1, 1, 2047, -2048));
		send_curve(make_curve(0, -5, 7, -9, 3, -1, -8, 0, 0));
		drain_segments();
		write_seg_log2(3'd7);
		send_curve(make_curve(1, 1, -1, -2048, 2047, 2047, -2048, -1, 1));
		send_curve(make_curve(0, 3, -3, 2047, 2047, -2048, -2048, 0, 0));
		drain_segments();
		write_seg_log2(3'd1);
		send_curve(make_curve(1, -3, -3, 5, 5, -7, 7, 1, -1));
		send_curve(make_curve(0, 2047, -2048, -2048, 2047, 2047, -2048, 0, 0));
		drain_segments();
	endtask

	// Hold the receiver off long enough that the block fills and stalls its input.
	task automatic test_output_stall();
		write_seg_log2(3'd4);
		hold_off_len = HOLD_LEN;
		repeat (6)
			send_curve(random_curve());
		drain_segments();
	endtask

	// Random curves over many settings, mostly small segment counts.
	task automatic test_random_curves(input int count);
		int sent;
		int batch;
		int r;
		logic [CFG_W-1:0] k;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 19);
			if (r < 12)
				k = CFG_W'($urandom_range(1, 3));
			else if (r < 16)
				k = 3'd4;
			else if (r < 18)
				k = 3'd5;
			else if (r == 18)
				k = 3'd6;
			else
				k = $urandom_range(0, 1) ? 3'd7 : 3'd0;
			write_seg_log2(k);
			batch = (k == 3'd0 || k >= 3'd6) ? $urandom_range(1, 4) : $urandom_range(8, 24);
			for (int b = 0; b < batch && sent < count; b++) begin
				send_curve(random_curve());
				sent++;
			end
			drain_segments();
		end
	endtask

	// Closing stretch: no gaps on either side.
	task automatic test_back_to_back();
		idle_on = 1'b0;
		write_seg_log2(3'd2);
		repeat (20)
			send_curve(random_curve());
		drain_segments();
	endtask

	// Receiver: random stall bursts, one long hold-off on request, else ready.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_len) @(negedge clk);
				hold_off_len = 0;
				m_axis_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare every segment transfer with the oldest one owed.
	always @(posedge clk) begin : check_segments
		segment_t got;
		segment_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.from_x = m_axis_tdata[CB-1:0];
			got.from_y = m_axis_tdata[2*CB-1:CB];
			got.to_x   = m_axis_tdata[3*CB-1:2*CB];
			got.to_y   = m_axis_tdata[4*CB-1:3*CB];
			got.last   = m_axis_tlast;
			segments_seen++;
			if (segments_due.size() == 0) begin
				report_mismatch("segment with nothing owed, to_x", got.to_x, 0);
			end else begin
				want = segments_due.pop_front();
				if (got.from_x !== want.from_x)
					report_mismatch("seg_from_x", got.from_x, want.from_x);
				if (got.from_y !== want.from_y)
					report_mismatch("seg_from_y", got.from_y, want.from_y);
				if (got.to_x !== want.to_x)
					report_mismatch("seg_to_x", got.to_x, want.to_x);
				if (got.to_y !== want.to_y)
					report_mismatch("seg_to_y", got.to_y, want.to_y);
				if (got.last !== want.last)
					report_mismatch("last_segment", got.last, want.last);
			end
		end
	end

	// Watchdog: abandon the run after too many cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("Timeout: no transfer for %0d cycles, %0d segments owed",
					stall_cycles, segments_due.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		seg_log2_cfg  = SEG_LOG2_RESET;
		idle_on       = 1'b1;
		hold_off_len  = 0;
		errors        = 0;
		curves_sent   = 0;
		cubic_sent    = 0;
		segments_seen = 0;
		cfg_writes    = 0;
		k_used        = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_curves();
		test_register_limits();
		test_output_stall();
		test_random_curves(380);
		test_back_to_back();

		// Let any stray segment show up before judging.
		repeat (20) @(posedge clk);
		if (segments_due.size() > 0)
			report_mismatch("segments never delivered", 0, segments_due.size());

		$display("Run covered %0d curves (%0d cubic), %0d segments checked, %0d register writes",
			curves_sent, cubic_sent, segments_seen, cfg_writes);
		$display("Effective log2 segment counts exercised (bit per value): %b", k_used);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
